@@ rtl/sclt_pkg.sv @@
// Shared types and constants for the script command line tokenizer.
// No dependencies; imported by every module of the block.
package sclt_pkg;

    localparam int COMMAND_MAX  = 63;
    localparam int ARGUMENT_MAX = 15;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam logic ADDR_CMD_LIMIT = 1'b0;
    localparam logic ADDR_ARG_LIMIT = 1'b1;

    typedef enum logic [2:0] {
        ROLE_WS     = 3'd0,
        ROLE_CMD    = 3'd1,
        ROLE_ARG    = 3'd2,
        ROLE_DELIM  = 3'd3,
        ROLE_IGNORE = 3'd4
    } role_t;

    typedef struct packed {
        logic [5:0] cmd_limit;
        logic [3:0] arg_limit;
    } limits_t;

    typedef struct packed {
        role_t      byte_role;
        logic       argument_begins;
        logic [3:0] argument_index;
        logic [3:0] argument_total;
        logic [5:0] command_length;
    } result_t;

endpackage

@@ rtl/script_command_line_tokenizer.sv @@
// Top level of the script command line tokenizer: input register, parser, result register.
// Depends on sclt_pkg, sclt_cfg and sclt_parse.
//
// Usage:
//   s_axis carries one byte of a command line per request; s_axis_tlast marks the
//   final byte of the line, after which the parser returns to its start state.
//   m_axis returns one tagged result per byte, in order; m_axis_tlast copies the
//   input tlast.
//   The APB port holds the command length limit (offset 0x0) and the argument
//   limit (offset 0x4); write them only while no byte is in flight.
// Timing:
//   The byte lands in the input register at the handshake edge, and the phase logic
//   loads the result register from it at the first later edge on which the output
//   register is free (empty or being taken).
//   Throughput is one byte per cycle while m_axis_tready holds high; the phase walk is combinational.
// Reset:
//   rst_n clears both pipeline valids and the parse state; limits return to
//   31 command characters and 8 arguments.
// Backpressure:
//   When m_axis_tready is low the result holds, the input register keeps one
//   more byte, and s_axis_tready drops once both are full.
module script_command_line_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] line_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [2:0] byte_role, [3] argument_begins,
                                        // [7:4] argument_index, [11:8] argument_total,
                                        // [17:12] command_length, [23:18] zero
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import sclt_pkg::*;

    limits_t    limits;
    result_t    parse_result;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_end_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_result_reg;
    logic       out_last_reg;
    logic       out_free;
    logic       advance;
    logic       in_take;

    sclt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .limits  (limits)
    );

    sclt_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .line_byte (in_byte_reg),
        .line_end  (in_end_reg),
        .limits    (limits),
        .result    (parse_result)
    );

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_byte_reg <= s_axis_tdata;
            in_end_reg  <= s_axis_tlast;
        end
        if (advance)
        begin
            out_result_reg <= parse_result;
            out_last_reg   <= in_end_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0,
                            out_result_reg.command_length,
                            out_result_reg.argument_total,
                            out_result_reg.argument_index,
                            out_result_reg.argument_begins,
                            out_result_reg.byte_role};

    a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_input_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_byte_reg)
                                     && $stable(in_end_reg))
        else $error("pending input byte lost while output stalled");

    a_begin_role: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_result_reg.argument_begins |->
            (out_result_reg.byte_role == ROLE_ARG || out_result_reg.byte_role == ROLE_DELIM)
            && (out_result_reg.argument_total == out_result_reg.argument_index + 4'd1))
        else $error("argument start with inconsistent role or count");

endmodule

@@ rtl/sclt_cfg.sv @@
// APB register file holding the command length and argument limits.
// Depends on sclt_pkg.
module sclt_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output sclt_pkg::limits_t   limits
);
    import sclt_pkg::*;

    logic [5:0] cmd_limit_reg;
    logic [3:0] arg_limit_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_limit_reg <= 6'd31;
            arg_limit_reg <= 4'd8;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                ADDR_CMD_LIMIT: cmd_limit_reg <= pwdata[5:0];
                ADDR_ARG_LIMIT: arg_limit_reg <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            ADDR_CMD_LIMIT: prdata = {26'd0, cmd_limit_reg};
            ADDR_ARG_LIMIT: prdata = {28'd0, arg_limit_reg};
            default:        prdata = 32'd0;
        endcase
    end

    assign limits = '{cmd_limit: cmd_limit_reg, arg_limit: arg_limit_reg};

endmodule

@@ rtl/sclt_parse.sv @@
// Parse state registers and the per-byte phase walk that tags one byte.
// Depends on sclt_pkg.
module sclt_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic [7:0]          line_byte,
    input  logic                line_end,
    input  sclt_pkg::limits_t   limits,
    output sclt_pkg::result_t   result
);
    import sclt_pkg::*;

    typedef enum logic [11:0] {
        PH_LEAD        = 12'b0000_0000_0001,
        PH_CMD         = 12'b0000_0000_0010,
        PH_AFTER_CMD   = 12'b0000_0000_0100,
        PH_LIST_TOP    = 12'b0000_0000_1000,
        PH_ARG_START   = 12'b0000_0001_0000,
        PH_ARG_BODY    = 12'b0000_0010_0000,
        PH_AFTER_COMMA = 12'b0000_0100_0000,
        PH_SKIP        = 12'b0000_1000_0000,
        PH_BRACE_CHECK = 12'b0001_0000_0000,
        PH_BRACE_FIRST = 12'b0010_0000_0000,
        PH_BRACE_BODY  = 12'b0100_0000_0000,
        PH_DONE        = 12'b1000_0000_0000
    } phase_t;

    typedef struct packed {
        phase_t     phase;
        logic       taken;
        role_t      role;
        logic       begins;
        logic [3:0] idx;
        logic [5:0] cmd_cnt;
        logic [3:0] arg_cnt;
    } step_t;

    localparam int STEPS = 6;

    phase_t     phase_reg, phase_next;
    logic [5:0] cmd_cnt_reg, cmd_cnt_next;
    logic [3:0] arg_cnt_reg, arg_cnt_next;
    logic [5:0] cmd_lim;
    logic [3:0] arg_lim;
    step_t      walk [0:STEPS];

    assign cmd_lim = (int'(limits.cmd_limit) < COMMAND_MAX) ? limits.cmd_limit
                                                            : 6'(COMMAND_MAX);
    assign arg_lim = (int'(limits.arg_limit) < ARGUMENT_MAX) ? limits.arg_limit
                                                             : 4'(ARGUMENT_MAX);

    function automatic step_t step(step_t s, logic [7:0] c, logic [5:0] clim,
                                   logic [3:0] alim);
        step_t r;
        logic  blank;
        r        = s;
        r.role   = ROLE_IGNORE;
        r.begins = 1'b0;
        r.idx    = 4'd0;
        r.taken  = 1'b0;
        blank    = (c == CH_SPACE) || (c == CH_TAB);
        unique case (s.phase)
            PH_LEAD:
            begin
                if (blank)
                begin
                    r.role  = ROLE_WS;
                    r.taken = 1'b1;
                end
                else
                    r.phase = PH_CMD;
            end
            PH_CMD:
            begin
                if (c != CH_NUL && c != CH_LPAREN && c != CH_LBRACE && !blank
                    && s.cmd_cnt < clim)
                begin
                    r.cmd_cnt = s.cmd_cnt + 6'd1;
                    r.role    = ROLE_CMD;
                    r.taken   = 1'b1;
                end
                else
                    r.phase = PH_AFTER_CMD;
            end
            PH_AFTER_CMD:
            begin
                if (c == CH_LPAREN)
                begin
                    r.role  = ROLE_DELIM;
                    r.phase = PH_LIST_TOP;
                    r.taken = 1'b1;
                end
                else
                    r.phase = PH_BRACE_CHECK;
            end
            PH_LIST_TOP:
            begin
                if (c == CH_NUL)
                begin
                    r.phase = PH_DONE;
                    r.taken = 1'b1;
                end
                else if (c == CH_RPAREN || c == CH_LBRACE || s.arg_cnt >= alim)
                    r.phase = PH_SKIP;
                else
                    r.phase = PH_ARG_START;
            end
            PH_ARG_START:
            begin
                r.taken = 1'b1;
                if (blank)
                    r.role = ROLE_WS;
                else
                begin
                    r.idx     = s.arg_cnt;
                    r.arg_cnt = s.arg_cnt + 4'd1;
                    r.begins  = 1'b1;
                    r.role    = ROLE_DELIM;
                    if (c == CH_COMMA)
                        r.phase = PH_AFTER_COMMA;
                    else if (c == CH_RPAREN)
                        r.phase = PH_LIST_TOP;
                    else if (c == CH_NUL)
                        r.phase = PH_DONE;
                    else
                    begin
                        r.role  = ROLE_ARG;
                        r.phase = PH_ARG_BODY;
                    end
                end
            end
            PH_ARG_BODY:
            begin
                r.taken = 1'b1;
                r.idx   = s.arg_cnt - 4'd1;
                if (c == CH_COMMA)
                begin
                    r.role  = ROLE_DELIM;
                    r.phase = PH_AFTER_COMMA;
                end
                else if (c == CH_RPAREN)
                begin
                    r.role  = ROLE_DELIM;
                    r.phase = PH_LIST_TOP;
                end
                else if (c == CH_NUL)
                begin
                    r.idx   = 4'd0;
                    r.phase = PH_DONE;
                end
                else
                    r.role = ROLE_ARG;
            end
            PH_AFTER_COMMA:
            begin
                if (c == CH_RPAREN)
                begin
                    r.role  = ROLE_DELIM;
                    r.taken = 1'b1;
                end
                r.phase = PH_LIST_TOP;
            end
            PH_SKIP:
            begin
                if (c == CH_NUL)
                begin
                    r.phase = PH_DONE;
                    r.taken = 1'b1;
                end
                else if (c == CH_RPAREN)
                begin
                    r.role  = ROLE_DELIM;
                    r.phase = PH_BRACE_CHECK;
                    r.taken = 1'b1;
                end
                else if (c == CH_LBRACE)
                    r.phase = PH_BRACE_CHECK;
                else
                    r.taken = 1'b1;
            end
            PH_BRACE_CHECK:
            begin
                if (c == CH_LBRACE && s.arg_cnt < alim)
                begin
                    r.role  = ROLE_DELIM;
                    r.phase = PH_BRACE_FIRST;
                    r.taken = 1'b1;
                end
                else
                    r.phase = PH_DONE;
            end
            PH_BRACE_FIRST:
            begin
                r.taken = 1'b1;
                if (c == CH_NUL)
                    r.phase = PH_DONE;
                else
                begin
                    r.idx     = s.arg_cnt;
                    r.arg_cnt = s.arg_cnt + 4'd1;
                    r.begins  = 1'b1;
                    if (c == CH_RBRACE)
                    begin
                        r.role  = ROLE_DELIM;
                        r.phase = PH_DONE;
                    end
                    else
                    begin
                        r.role  = ROLE_ARG;
                        r.phase = PH_BRACE_BODY;
                    end
                end
            end
            PH_BRACE_BODY:
            begin
                r.taken = 1'b1;
                r.idx   = s.arg_cnt - 4'd1;
                if (c == CH_RBRACE)
                begin
                    r.role  = ROLE_DELIM;
                    r.phase = PH_DONE;
                end
                else if (c == CH_NUL)
                begin
                    r.idx   = 4'd0;
                    r.phase = PH_DONE;
                end
                else
                    r.role = ROLE_ARG;
            end
            default:
            begin
                r.phase = PH_DONE;
                r.taken = 1'b1;
            end
        endcase
        return r;
    endfunction

    // a byte passes through at most five phases before it is taken
    always_comb
    begin
        walk[0] = '{phase: phase_reg, taken: 1'b0, role: ROLE_IGNORE, begins: 1'b0,
                    idx: 4'd0, cmd_cnt: cmd_cnt_reg, arg_cnt: arg_cnt_reg};
        for (int k = 0; k < STEPS; k++)
            walk[k+1] = walk[k].taken ? walk[k] : step(walk[k], line_byte, cmd_lim, arg_lim);
    end

    always_comb
    begin
        if (line_end)
        begin
            phase_next   = PH_LEAD;
            cmd_cnt_next = 6'd0;
            arg_cnt_next = 4'd0;
        end
        else
        begin
            phase_next   = walk[STEPS].phase;
            cmd_cnt_next = walk[STEPS].cmd_cnt;
            arg_cnt_next = walk[STEPS].arg_cnt;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_LEAD;
            cmd_cnt_reg <= 6'd0;
            arg_cnt_reg <= 4'd0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            cmd_cnt_reg <= cmd_cnt_next;
            arg_cnt_reg <= arg_cnt_next;
        end
    end

    assign result = '{byte_role:       walk[STEPS].role,
                      argument_begins: walk[STEPS].begins,
                      argument_index:  walk[STEPS].idx,
                      argument_total:  walk[STEPS].arg_cnt,
                      command_length:  walk[STEPS].cmd_cnt};

endmodule
